@@ hdl/stig_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package stig_pkg;

   localparam int REGION_BITS    = 17;
   localparam logic [REGION_BITS-1:0] REGION_MAX = '1;
   localparam int LEN_BITS       = 16;
   localparam int FIELD_BITS     = 16;
   localparam int OUT_COORD_BITS = 16;
   localparam int PACKED_DIMS    = 4;
   localparam int PACKED_OPS     = 4;
   localparam int SHAPE_BITS     = 64;
   localparam int OP_BITS        = 50;
   localparam int USED_BITS      = 3;
   localparam int STEP_BITS      = 3;
   localparam int COUNT_BITS     = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   localparam int OP_DIM_LSB    = 0;
   localparam int OP_STRIDE_LSB = 2;
   localparam int OP_SIZE_LSB   = 18;
   localparam int OP_COUNT_LSB  = 34;

   localparam logic [USED_BITS-1:0]  DIMS_USED_RESET = 3'd2;
   localparam logic [SHAPE_BITS-1:0] SHAPE_RESET     = 64'd262148;
   localparam logic [USED_BITS-1:0]  OPS_USED_RESET  = 3'd2;
   localparam logic [OP_BITS-1:0]    OP_ZERO_RESET   = 50'd34360262664;
   localparam logic [OP_BITS-1:0]    OP_ONE_RESET    = 50'd34360262665;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DIMS_USED,
      CSR_SHAPE_PACKED,
      CSR_OPS_USED,
      CSR_OP_ZERO,
      CSR_OP_ONE,
      CSR_OP_TWO,
      CSR_OP_THREE
   } stig_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RG_INIT,
      ST_RG_OP,
      ST_RG_COPY,
      ST_IDX,
      ST_ADV
   } stig_state_type;

   typedef struct packed {
      logic                 clear_tiles;
      logic                 region_init;
      logic                 region_op;
      logic                 region_copy;
      logic                 idx_step;
      logic                 advance;
      logic [STEP_BITS-1:0] step;
   } stig_cmd_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] eff_dims;
      logic [COUNT_BITS-1:0] eff_ops;
      logic                  carry;
      logic                  out_free;
      logic                  cfg_hit;
   } stig_status_type;

endpackage

`default_nettype wire

@@ hdl/stig_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface stig_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface stig_rsp_if
   import stig_pkg::*;
   #(parameter int INDEX_BITS = 32);
   logic                      valid;
   logic                      ready;
   logic [INDEX_BITS-1:0]     linear_index;
   logic [OUT_COORD_BITS-1:0] tile_coord_zero;
   logic [OUT_COORD_BITS-1:0] tile_coord_one;
   logic [OUT_COORD_BITS-1:0] tile_coord_two;
   logic [OUT_COORD_BITS-1:0] tile_coord_three;
   logic                      last_in_tile;
   logic                      last_of_all;
   logic                      outside_shape;

   modport source (output valid, output linear_index, output tile_coord_zero,
                   output tile_coord_one, output tile_coord_two, output tile_coord_three,
                   output last_in_tile, output last_of_all, output outside_shape,
                   input ready);
   modport sink (input valid, input linear_index, input tile_coord_zero,
                 input tile_coord_one, input tile_coord_two, input tile_coord_three,
                 input last_in_tile, input last_of_all, input outside_shape,
                 output ready);
endinterface

`default_nettype wire

@@ hdl/strided_tile_index_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Port      Dir  Handshake     Word
// req_bus   in   valid/ready   restart
// rsp_bus   out  valid/ready   linear_index, tile coords, last/outside flags
// csr_*     in   write enable  register index, 64-bit write data
//
// One word at a time. A word takes one multiply-add per dimension in use for the
// index, plus one tile*stride per op in use to rebuild the regions when the tile
// changes, and the same rebuild once more on restart.
// Reset and any write to a mapped register restart the walk on the next accepted word.
// The response sits in an output register; a stalled response holds the block
// only when the next response is ready to load.

module strided_tile_index_generator
   import stig_pkg::*;
#(
   parameter int MAX_DIMS   = 4,
   parameter int MAX_OPS    = 4,
   parameter int COORD_BITS = 16,
   parameter int INDEX_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   stig_req_if.sink                       req_bus,
   stig_rsp_if.source                     rsp_bus,
   input  wire logic                      csr_write_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   stig_cmd_type    cmd;
   stig_status_type status;
   logic            req_ready;

   stig_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_restart (req_bus.restart),
      .status      (status),
      .req_ready   (req_ready),
      .cmd         (cmd)
   );

   assign req_bus.ready = req_ready;

   stig_datapath #(
      .MAX_DIMS   (MAX_DIMS),
      .MAX_OPS    (MAX_OPS),
      .COORD_BITS (COORD_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .rsp_ready        (rsp_bus.ready),
      .status           (status),
      .rsp_valid        (rsp_bus.valid),
      .linear_index     (rsp_bus.linear_index),
      .tile_coord_zero  (rsp_bus.tile_coord_zero),
      .tile_coord_one   (rsp_bus.tile_coord_one),
      .tile_coord_two   (rsp_bus.tile_coord_two),
      .tile_coord_three (rsp_bus.tile_coord_three),
      .last_in_tile     (rsp_bus.last_in_tile),
      .last_of_all      (rsp_bus.last_of_all),
      .outside_shape    (rsp_bus.outside_shape)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while a word is in flight");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> status.out_free)
      else $error("output register overwritten");

   a_op_step_range: assert property (@(posedge clock) disable iff (reset)
      cmd.region_op |-> ({1'b0, cmd.step} < status.eff_ops))
      else $error("region op step out of range");

   a_idx_step_range: assert property (@(posedge clock) disable iff (reset)
      cmd.idx_step |-> ({1'b0, cmd.step} < status.eff_dims))
      else $error("index step out of range");

   a_rsp_from_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(cmd.advance))
      else $error("response raised without an advance");

endmodule

`default_nettype wire

@@ hdl/stig_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stig_ctrl
   import stig_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_restart,
   input  wire stig_status_type status,
   output logic                 req_ready,
   output stig_cmd_type         cmd
);

   stig_state_type       state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 from_req_ff, from_req_in;
   logic                 pending_ff, pending_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         step_ff     <= '0;
         from_req_ff <= 1'b0;
         pending_ff  <= 1'b1;
      end else begin
         state_ff    <= state_in;
         step_ff     <= step_in;
         from_req_ff <= from_req_in;
         pending_ff  <= pending_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      from_req_in = from_req_ff;
      pending_in  = pending_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.step    = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_restart || pending_ff) begin
                  pending_in  = 1'b0;
                  from_req_in = 1'b1;
                  state_in    = ST_RG_INIT;
               end else begin
                  step_in  = '0;
                  state_in = ST_IDX;
               end
            end
         end
         ST_RG_INIT: begin
            cmd.region_init = 1'b1;
            cmd.clear_tiles = from_req_ff;
            step_in         = '0;
            state_in        = (status.eff_ops == '0) ? ST_RG_COPY : ST_RG_OP;
         end
         ST_RG_OP: begin
            cmd.region_op = 1'b1;
            if ({1'b0, step_ff} == status.eff_ops - 1'b1) begin
               state_in = ST_RG_COPY;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_RG_COPY: begin
            cmd.region_copy = 1'b1;
            if (from_req_ff) begin
               step_in  = '0;
               state_in = ST_IDX;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_IDX: begin
            cmd.idx_step = 1'b1;
            if ({1'b0, step_ff} == status.eff_dims - 1'b1) begin
               state_in = ST_ADV;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_ADV: begin
            if (status.out_free) begin
               cmd.advance = 1'b1;
               if (status.carry) begin
                  from_req_in = 1'b0;
                  state_in    = ST_RG_INIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (status.cfg_hit) begin
         pending_in = 1'b1;
      end
   end

endmodule

`default_nettype wire

@@ hdl/stig_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stig_datapath
   import stig_pkg::*;
#(
   parameter int MAX_DIMS   = 4,
   parameter int MAX_OPS    = 4,
   parameter int COORD_BITS = 16,
   parameter int INDEX_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire stig_cmd_type              cmd,
   input  wire logic                      rsp_ready,
   output stig_status_type                status,
   output logic                           rsp_valid,
   output logic [INDEX_BITS-1:0]          linear_index,
   output logic [OUT_COORD_BITS-1:0]      tile_coord_zero,
   output logic [OUT_COORD_BITS-1:0]      tile_coord_one,
   output logic [OUT_COORD_BITS-1:0]      tile_coord_two,
   output logic [OUT_COORD_BITS-1:0]      tile_coord_three,
   output logic                           last_in_tile,
   output logic                           last_of_all,
   output logic                           outside_shape
);

   localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int OW = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
   localparam int PW = COORD_BITS + FIELD_BITS;
   localparam int CW = ((COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS) + 1;
   localparam int XW = INDEX_BITS + LEN_BITS;

   // configuration
   logic [USED_BITS-1:0]  dims_used_ff;
   logic [SHAPE_BITS-1:0] shape_ff;
   logic [USED_BITS-1:0]  ops_used_ff;
   logic [OP_BITS-1:0]    op_ff [PACKED_OPS];

   // walk state
   logic [COORD_BITS-1:0]  tile_ff  [MAX_OPS];
   logic [REGION_BITS-1:0] pos_ff   [MAX_DIMS];
   logic [REGION_BITS-1:0] start_ff [MAX_DIMS];
   logic [REGION_BITS-1:0] end_ff   [MAX_DIMS];
   logic [INDEX_BITS-1:0]  acc_ff, acc_in;
   logic                   outside_ff, outside_in;

   // output word
   logic                      rsp_valid_ff;
   logic [INDEX_BITS-1:0]     index_ff;
   logic [OUT_COORD_BITS-1:0] coord_ff [PACKED_OPS];
   logic                      last_tile_ff, last_all_ff, outside_out_ff;

   logic [COUNT_BITS-1:0]  eff_dims, eff_ops;
   logic [OP_BITS-1:0]     opw      [MAX_OPS];
   logic [COORD_BITS-1:0]  tile_pad [PACKED_OPS];
   logic [LEN_BITS-1:0]    lens     [MAX_DIMS];

   logic [LEN_BITS-1:0]    len_sel;
   logic [REGION_BITS-1:0] pos_sel;
   logic [XW-1:0]          idx_prod;

   logic [OP_BITS-1:0]     w_sel;
   logic [1:0]             op_dim;
   logic [DW-1:0]          dim_idx;
   logic                   op_hit;
   logic [COORD_BITS-1:0]  tile_sel;
   logic [PW-1:0]          stride_prod;
   logic [PW:0]            start_sum;
   logic [REGION_BITS-1:0] start_new;
   logic [REGION_BITS:0]   end_sum;
   logic [REGION_BITS-1:0] end_new;

   logic [REGION_BITS-1:0] pos_next  [MAX_DIMS];
   logic [COORD_BITS-1:0]  tile_next [MAX_OPS];
   logic                   carry, wrap;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_used_ff <= DIMS_USED_RESET;
         shape_ff     <= SHAPE_RESET;
         ops_used_ff  <= OPS_USED_RESET;
         op_ff[0]     <= OP_ZERO_RESET;
         op_ff[1]     <= OP_ONE_RESET;
         op_ff[2]     <= '0;
         op_ff[3]     <= '0;
      end else if (csr_write_en) begin
         unique case (stig_csr_type'(csr_index))
            CSR_DIMS_USED:    dims_used_ff <= csr_wdata[USED_BITS-1:0];
            CSR_SHAPE_PACKED: shape_ff     <= csr_wdata[SHAPE_BITS-1:0];
            CSR_OPS_USED:     ops_used_ff  <= csr_wdata[USED_BITS-1:0];
            CSR_OP_ZERO:      op_ff[0]     <= csr_wdata[OP_BITS-1:0];
            CSR_OP_ONE:       op_ff[1]     <= csr_wdata[OP_BITS-1:0];
            CSR_OP_TWO:       op_ff[2]     <= csr_wdata[OP_BITS-1:0];
            CSR_OP_THREE:     op_ff[3]     <= csr_wdata[OP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (dims_used_ff == '0) begin
         eff_dims = COUNT_BITS'(1);
      end else if (COUNT_BITS'(dims_used_ff) > COUNT_BITS'(MAX_DIMS)) begin
         eff_dims = COUNT_BITS'(MAX_DIMS);
      end else begin
         eff_dims = COUNT_BITS'(dims_used_ff);
      end
      if (COUNT_BITS'(ops_used_ff) > COUNT_BITS'(MAX_OPS)) begin
         eff_ops = COUNT_BITS'(MAX_OPS);
      end else begin
         eff_ops = COUNT_BITS'(ops_used_ff);
      end
   end

   // ops past the packed four read as all zero; dims past four have length zero
   for (genvar g = 0; g < MAX_OPS; g++) begin : g_opw
      if (g < PACKED_OPS) begin : g_real
         assign opw[g] = op_ff[g];
      end else begin : g_none
         assign opw[g] = '0;
      end
   end

   for (genvar g = 0; g < PACKED_OPS; g++) begin : g_tile_pad
      if (g < MAX_OPS) begin : g_real
         assign tile_pad[g] = tile_ff[g];
      end else begin : g_none
         assign tile_pad[g] = '0;
      end
   end

   for (genvar g = 0; g < MAX_DIMS; g++) begin : g_lens
      if (g < PACKED_DIMS) begin : g_real
         assign lens[g] = shape_ff[g*LEN_BITS +: LEN_BITS];
      end else begin : g_none
         assign lens[g] = '0;
      end
   end

   // index: one Horner step per cycle
   always_comb begin
      len_sel  = lens[DW'(cmd.step)];
      pos_sel  = pos_ff[DW'(cmd.step)];
      idx_prod = ((cmd.step == '0) ? '0 : acc_ff) * len_sel;
      acc_in   = INDEX_BITS'(idx_prod + XW'(pos_sel));
      outside_in = ((cmd.step == '0) ? 1'b0 : outside_ff) ||
                   (pos_sel >= REGION_BITS'(len_sel));
   end

   // region narrowing: one op per cycle
   always_comb begin
      w_sel       = opw[OW'(cmd.step)];
      op_dim      = w_sel[OP_DIM_LSB +: 2];
      dim_idx     = DW'(op_dim);
      op_hit      = COUNT_BITS'(op_dim) < eff_dims;
      tile_sel    = tile_ff[OW'(cmd.step)];
      stride_prod = tile_sel * w_sel[OP_STRIDE_LSB +: FIELD_BITS];
      start_sum   = (PW+1)'(start_ff[dim_idx]) + (PW+1)'(stride_prod);
      start_new   = (start_sum > (PW+1)'(REGION_MAX)) ? REGION_MAX
                                                      : start_sum[REGION_BITS-1:0];
      end_sum     = (REGION_BITS+1)'(start_new) +
                    (REGION_BITS+1)'(w_sel[OP_SIZE_LSB +: FIELD_BITS]);
      end_new     = (end_sum > (REGION_BITS+1)'(REGION_MAX)) ? REGION_MAX
                                                             : end_sum[REGION_BITS-1:0];
   end

   // position advance, last dim fastest
   always_comb begin
      logic [REGION_BITS:0] pos_inc;
      pos_inc  = '0;
      pos_next = pos_ff;
      carry    = 1'b1;
      for (int d = MAX_DIMS - 1; d >= 0; d--) begin
         if (carry && (COUNT_BITS'(d) < eff_dims)) begin
            pos_inc = (REGION_BITS+1)'(pos_ff[d]) + 1'b1;
            if (pos_inc < (REGION_BITS+1)'(end_ff[d])) begin
               pos_next[d] = pos_inc[REGION_BITS-1:0];
               carry       = 1'b0;
            end else begin
               pos_next[d] = start_ff[d];
            end
         end
      end
   end

   // tile advance, last op fastest
   always_comb begin
      logic [CW-1:0] fld, cnt, inc;
      fld       = '0;
      cnt       = '0;
      inc       = '0;
      tile_next = tile_ff;
      wrap      = 1'b1;
      for (int k = MAX_OPS - 1; k >= 0; k--) begin
         if (wrap && (COUNT_BITS'(k) < eff_ops)) begin
            fld = CW'(opw[k][OP_COUNT_LSB +: FIELD_BITS]);
            if (fld == '0) begin
               cnt = CW'(1);
            end else if (fld > (CW'(1) << COORD_BITS)) begin
               cnt = CW'(1) << COORD_BITS;
            end else begin
               cnt = fld;
            end
            inc = CW'(tile_ff[k]) + 1'b1;
            if (inc < cnt) begin
               tile_next[k] = inc[COORD_BITS-1:0];
               wrap         = 1'b0;
            end else begin
               tile_next[k] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_tiles) begin
         for (int k = 0; k < MAX_OPS; k++) begin
            tile_ff[k] <= '0;
         end
      end else if (cmd.advance && carry) begin
         tile_ff <= tile_next;
      end
      if (cmd.region_init) begin
         for (int d = 0; d < MAX_DIMS; d++) begin
            start_ff[d] <= '0;
            end_ff[d]   <= REGION_BITS'(lens[d]);
         end
      end else if (cmd.region_op && op_hit) begin
         start_ff[dim_idx] <= start_new;
         end_ff[dim_idx]   <= end_new;
      end
      if (cmd.region_copy) begin
         pos_ff <= start_ff;
      end else if (cmd.advance) begin
         pos_ff <= pos_next;
      end
      if (cmd.idx_step) begin
         acc_ff     <= acc_in;
         outside_ff <= outside_in;
      end
      if (cmd.advance) begin
         index_ff       <= acc_ff;
         outside_out_ff <= outside_ff;
         last_tile_ff   <= carry;
         last_all_ff    <= carry && wrap;
         for (int i = 0; i < PACKED_OPS; i++) begin
            coord_ff[i] <= (COUNT_BITS'(i) < eff_ops) ? OUT_COORD_BITS'(tile_pad[i]) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      status.eff_dims = eff_dims;
      status.eff_ops  = eff_ops;
      status.carry    = carry;
      status.out_free = !rsp_valid_ff || rsp_ready;
      status.cfg_hit  = csr_write_en && (csr_index <= CSR_OP_THREE);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign linear_index     = index_ff;
   assign tile_coord_zero  = coord_ff[0];
   assign tile_coord_one   = coord_ff[1];
   assign tile_coord_two   = coord_ff[2];
   assign tile_coord_three = coord_ff[3];
   assign last_in_tile     = last_tile_ff;
   assign last_of_all      = last_all_ff;
   assign outside_shape    = outside_out_ff;

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import stig_pkg::*;

   localparam int IDX_W         = 32;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_WORDS  = 1750;
   localparam int PRINT_CAP     = 40;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 3'd7;

   typedef enum {SOURCE_STEADY, SOURCE_BURSTY} source_mode_type;
   typedef enum {SINK_OPEN, SINK_JITTER, SINK_CHOKE} sink_mode_type;

   typedef struct packed {
      logic [IDX_W-1:0]                       linear_index;
      logic [PACKED_OPS-1:0][OUT_COORD_BITS-1:0] tile_coord;
      logic                                   last_in_tile;
      logic                                   last_of_all;
      logic                                   outside_shape;
   } index_word_type;

   logic clock;
   logic reset = 1'b1;
   logic                      csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index    = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata    = '0;

   stig_req_if req_bus ();
   stig_rsp_if #(.INDEX_BITS(IDX_W)) rsp_bus ();

   strided_tile_index_generator #(
      .MAX_DIMS(4),
      .MAX_OPS(4),
      .COORD_BITS(16),
      .INDEX_BITS(IDX_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // walk state mirrored from the block
   logic [USED_BITS-1:0]   cfg_dims;
   logic [USED_BITS-1:0]   cfg_ops;
   logic [SHAPE_BITS-1:0]  cfg_shape;
   logic [OP_BITS-1:0]     cfg_op    [PACKED_OPS];
   logic [FIELD_BITS-1:0]  tile_ctr  [PACKED_OPS];
   logic [REGION_BITS-1:0] pos_ctr   [PACKED_DIMS];
   logic [REGION_BITS-1:0] reg_start [PACKED_DIMS];
   logic [REGION_BITS-1:0] reg_end   [PACKED_DIMS];

   logic           restart_queue [$];
   index_word_type index_words_due [$];

   source_mode_type source_mode = SOURCE_STEADY;
   sink_mode_type   sink_mode   = SINK_OPEN;
   int burst_left = 1;
   int gap_left   = 0;
   int stall_left = 0;

   int unsigned cycle_count = 0;
   int mismatches   = 0;
   int words_seen   = 0;
   int restarts     = 0;
   int walks_done   = 0;
   int csr_writes   = 0;
   int random_words = 0;

   function automatic int dims_in_use();
      int n;
      n = cfg_dims;
      if (n == 0) n = 1;
      if (n > PACKED_DIMS) n = PACKED_DIMS;
      return n;
   endfunction

   function automatic int ops_in_use();
      int n;
      n = cfg_ops;
      if (n > PACKED_OPS) n = PACKED_OPS;
      return n;
   endfunction

   function automatic logic [LEN_BITS-1:0] dim_length(input int d);
      return cfg_shape[LEN_BITS*d +: LEN_BITS];
   endfunction

   function automatic logic [FIELD_BITS:0] tile_limit(input int k);
      logic [FIELD_BITS:0] c;
      c = {1'b0, cfg_op[k][OP_COUNT_LSB +: FIELD_BITS]};
      return (c == '0) ? (FIELD_BITS+1)'(1) : c;
   endfunction

   function automatic logic [REGION_BITS-1:0] clamp_region(input longint unsigned v);
      return (v > REGION_MAX) ? REGION_MAX : v[REGION_BITS-1:0];
   endfunction

   function automatic void rebuild_regions();
      int nd, no, d, k, dim;
      longint unsigned stride, size, acc;
      nd = dims_in_use();
      no = ops_in_use();
      for (d = 0; d < PACKED_DIMS; d++) begin
         reg_start[d] = '0;
         reg_end[d] = clamp_region(dim_length(d));
      end
      for (k = 0; k < no; k++) begin
         dim = cfg_op[k][OP_STRIDE_LSB-1:OP_DIM_LSB];
         stride = cfg_op[k][OP_STRIDE_LSB +: FIELD_BITS];
         size = cfg_op[k][OP_SIZE_LSB +: FIELD_BITS];
         if (dim < nd) begin
            acc = reg_start[dim];
            acc = acc + tile_ctr[k] * stride;
            reg_start[dim] = clamp_region(acc);
            acc = reg_start[dim];
            reg_end[dim] = clamp_region(acc + size);
         end
      end
      for (d = 0; d < PACKED_DIMS; d++) pos_ctr[d] = reg_start[d];
   endfunction

   function automatic void restart_walk();
      int k;
      for (k = 0; k < PACKED_OPS; k++) tile_ctr[k] = '0;
      rebuild_regions();
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                                     input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_DIMS_USED:    cfg_dims = data[USED_BITS-1:0];
         CSR_SHAPE_PACKED: cfg_shape = data;
         CSR_OPS_USED:     cfg_ops = data[USED_BITS-1:0];
         CSR_OP_ZERO:      cfg_op[0] = data[OP_BITS-1:0];
         CSR_OP_ONE:       cfg_op[1] = data[OP_BITS-1:0];
         CSR_OP_TWO:       cfg_op[2] = data[OP_BITS-1:0];
         CSR_OP_THREE:     cfg_op[3] = data[OP_BITS-1:0];
         default:          return;
      endcase
      restart_walk();
   endfunction

   function automatic index_word_type walk_next_index(input logic restart);
      index_word_type w;
      int nd, no, d, k;
      longint unsigned idx;
      logic [REGION_BITS:0] p;
      logic [FIELD_BITS:0] t;
      logic carry, wrap;
      if (restart) restart_walk();
      nd = dims_in_use();
      no = ops_in_use();
      idx = 0;
      w = '0;
      for (d = 0; d < nd; d++) begin
         idx = (idx * dim_length(d) + pos_ctr[d]) & 64'hFFFF_FFFF;
         if (pos_ctr[d] >= dim_length(d)) w.outside_shape = 1'b1;
      end
      w.linear_index = idx[IDX_W-1:0];
      for (k = 0; k < no; k++) w.tile_coord[k] = tile_ctr[k];
      // last dimension fastest
      carry = 1'b1;
      for (d = nd - 1; d >= 0 && carry; d--) begin
         p = pos_ctr[d] + 1'b1;
         if (p < reg_end[d]) begin
            pos_ctr[d] = p[REGION_BITS-1:0];
            carry = 1'b0;
         end else begin
            pos_ctr[d] = reg_start[d];
         end
      end
      w.last_in_tile = carry;
      if (carry) begin
         wrap = 1'b1;
         for (k = no - 1; k >= 0 && wrap; k--) begin
            t = tile_ctr[k] + 1'b1;
            if (t < tile_limit(k)) begin
               tile_ctr[k] = t[FIELD_BITS-1:0];
               wrap = 1'b0;
            end else begin
               tile_ctr[k] = '0;
            end
         end
         w.last_of_all = wrap;
         rebuild_regions();
      end
      return w;
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] op_word(input logic [1:0] dim,
         input logic [FIELD_BITS-1:0] stride, input logic [FIELD_BITS-1:0] size,
         input logic [FIELD_BITS-1:0] count);
      return {14'd0, count, size, stride, dim};
   endfunction

   function automatic logic [FIELD_BITS-1:0] pick_field(input int lo, input int hi);
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return '1;
         2:       return FIELD_BITS'($urandom);
         default: return FIELD_BITS'($urandom_range(lo, hi));
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] csr_value(input int r);
      logic [CSR_DATA_BITS-1:0] junk;
      logic [USED_BITS-1:0] n;
      junk = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
      case (r)
         CSR_DIMS_USED: begin
            n = ($urandom_range(0, 7) == 0) ? USED_BITS'($urandom_range(0, 7))
                                            : USED_BITS'($urandom_range(1, 4));
            return {junk[CSR_DATA_BITS-1:USED_BITS], n};
         end
         CSR_SHAPE_PACKED:
            return {pick_field(1, 5), pick_field(1, 5), pick_field(1, 5), pick_field(1, 5)};
         CSR_OPS_USED: begin
            n = ($urandom_range(0, 7) == 0) ? USED_BITS'($urandom_range(0, 7))
                                            : USED_BITS'($urandom_range(0, 4));
            return {junk[CSR_DATA_BITS-1:USED_BITS], n};
         end
         default:
            return op_word(2'($urandom), pick_field(0, 3), pick_field(0, 3), pick_field(0, 3))
                   | {junk[CSR_DATA_BITS-1:OP_BITS], {OP_BITS{1'b0}}};
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [IDX_W-1:0] want,
                                       input logic [IDX_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= PRINT_CAP)
            $display("%0t %s: expected %h, got %h", $time, name, want, got);
      end
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      apply_csr(idx, data);
      csr_writes++;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic drain_block();
      while (restart_queue.size() != 0 || index_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_pattern(input logic [31:0] pattern, input int n);
      int i;
      for (i = 0; i < n; i++) restart_queue = {restart_queue, pattern[i]};
      drain_block();
   endtask

   task automatic shuffle_config();
      int r;
      bit any;
      any = 1'b0;
      while (!any) begin
         for (r = CSR_DIMS_USED; r <= CSR_OP_THREE; r++) begin
            if ($urandom_range(0, 1) == 0) begin
               write_csr(r[CSR_INDEX_BITS-1:0], csr_value(r));
               any = 1'b1;
            end
         end
      end
      if ($urandom_range(0, 7) == 0) write_csr(CSR_UNMAPPED, {$urandom, $urandom});
   endtask

   task automatic run_phase(input int n, input int odds);
      int i;
      logic bit_in;
      for (i = 0; i < n; i++) begin
         if (i == n / 2) begin
            drain_block();
            source_mode = source_mode_type'($urandom_range(0, 1));
            sink_mode = sink_mode_type'($urandom_range(0, 2));
         end
         bit_in = ($urandom_range(0, odds - 1) == 0);
         restart_queue = {restart_queue, bit_in};
      end
      drain_block();
   endtask

   always @(posedge clock) cycle_count++;

   // request side: take the word at the edge, predict, then plan the next gap
   always @(posedge clock) begin
      logic restart_bit;
      index_word_type want;
      if (!reset && req_bus.valid && req_bus.ready) begin
         restart_bit = restart_queue.pop_front();
         want = walk_next_index(restart_bit);
         index_words_due = {index_words_due, want};
         if (restart_bit) restarts++;
         if (want.last_of_all) walks_done++;
         if (burst_left > 1) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = (source_mode == SOURCE_BURSTY) ? $urandom_range(0, 12) : 0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset || gap_left != 0 || restart_queue.size() == 0) begin
         if (!reset && gap_left != 0) gap_left--;
         req_bus.valid <= 1'b0;
      end else begin
         req_bus.valid <= 1'b1;
         req_bus.restart <= restart_queue[0];
      end
   end

   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !reset;
         case (sink_mode)
            SINK_JITTER: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 3);
            SINK_CHOKE:  if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(8, 30);
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      index_word_type got, want;
      int k;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.linear_index = rsp_bus.linear_index;
         got.tile_coord[0] = rsp_bus.tile_coord_zero;
         got.tile_coord[1] = rsp_bus.tile_coord_one;
         got.tile_coord[2] = rsp_bus.tile_coord_two;
         got.tile_coord[3] = rsp_bus.tile_coord_three;
         got.last_in_tile = rsp_bus.last_in_tile;
         got.last_of_all = rsp_bus.last_of_all;
         got.outside_shape = rsp_bus.outside_shape;
         words_seen++;
         if (index_words_due.size() == 0) begin
            mismatches++;
            if (mismatches <= PRINT_CAP)
               $display("%0t unexpected word: expected none, got index %h",
                        $time, got.linear_index);
         end else begin
            want = index_words_due.pop_front();
            check_field("linear_index", want.linear_index, got.linear_index);
            for (k = 0; k < PACKED_OPS; k++)
               check_field($sformatf("tile_coord[%0d]", k), IDX_W'(want.tile_coord[k]),
                           IDX_W'(got.tile_coord[k]));
            check_field("last_in_tile", IDX_W'(want.last_in_tile),
                        IDX_W'(got.last_in_tile));
            check_field("last_of_all", IDX_W'(want.last_of_all), IDX_W'(got.last_of_all));
            check_field("outside_shape", IDX_W'(want.outside_shape),
                        IDX_W'(got.outside_shape));
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d words still due", cycle_count,
               index_words_due.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int n, odds;
      req_bus.valid = 1'b0;
      req_bus.restart = 1'b0;
      rsp_bus.ready = 1'b0;
      cfg_dims = DIMS_USED_RESET;
      cfg_shape = SHAPE_RESET;
      cfg_ops = OPS_USED_RESET;
      cfg_op[0] = OP_ZERO_RESET;
      cfg_op[1] = OP_ONE_RESET;
      cfg_op[2] = '0;
      cfg_op[3] = '0;
      restart_walk();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk from reset, restart on the first word of the second tile
      queue_pattern(32'b010000, 6);

      // saturated counts, zero length, empty window, max tile count
      write_csr(CSR_DIMS_USED, '1);
      write_csr(CSR_SHAPE_PACKED, {16'hFFFF, 16'd0, 16'd1, 16'd2});
      write_csr(CSR_OPS_USED, '1);
      write_csr(CSR_OP_ZERO, op_word(2'd3, 16'hFFFF, 16'd0, 16'd0));
      write_csr(CSR_OP_ONE, op_word(2'd2, 16'd1, 16'd1, 16'd2));
      write_csr(CSR_OP_TWO, op_word(2'd0, 16'd0, 16'd2, 16'd1));
      write_csr(CSR_OP_THREE, op_word(2'd1, 16'd3, 16'hFFFF, 16'hFFFF));
      queue_pattern(32'b0, 4);

      // unmapped write leaves the walk where it was
      write_csr(CSR_UNMAPPED, '1);
      queue_pattern(32'b0, 2);

      // op on a dimension not in use still counts tiles
      write_csr(CSR_DIMS_USED, 64'd1);
      write_csr(CSR_OPS_USED, 64'd1);
      write_csr(CSR_SHAPE_PACKED, {48'd0, 16'd2});
      write_csr(CSR_OP_ZERO, op_word(2'd2, 16'd5, 16'd3, 16'd3));
      queue_pattern(32'b0, 7);

      // region start and end saturate
      write_csr(CSR_SHAPE_PACKED, {48'd0, 16'hFFFF});
      write_csr(CSR_OP_ZERO, op_word(2'd0, 16'hFFFF, 16'd1, 16'd4));
      queue_pattern(32'b0, 5);

      while (random_words < RANDOM_WORDS) begin
         shuffle_config();
         source_mode = source_mode_type'($urandom_range(0, 1));
         sink_mode = sink_mode_type'($urandom_range(0, 2));
         n = $urandom_range(40, 200);
         if (n > RANDOM_WORDS - random_words) n = RANDOM_WORDS - random_words;
         case ($urandom_range(0, 2))
            0:       odds = 4;
            1:       odds = 24;
            default: odds = 200;
         endcase
         run_phase(n, odds);
         random_words += n;
      end

      drain_block();
      if (index_words_due.size() != 0) mismatches++;
      $display("checked %0d index words over %0d register writes and %0d cycles",
               words_seen, csr_writes, cycle_count);
      $display("walk saw %0d restarts, %0d full wraps, %0d mismatches",
               restarts, walks_done, mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/stig_pkg.sv
hdl/stig_if.sv
hdl/stig_ctrl.sv
hdl/stig_datapath.sv
hdl/strided_tile_index_generator.sv
bench/testbench.sv
